/* rtl/vwi_pkg.sv */
`timescale 1ns / 1ps
package vwi_pkg;

  // Field and datapath widths
  localparam int COORD_W    = 32;
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int DIVIDEND_W = 48;
  localparam int DIV_CNT_W  = 6;
  localparam int CAP_W      = 11;
  localparam int TOL_W      = 31;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int VIDX_W     = 10;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_VTX_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IDX_FULL = 2'd2;

  // Configuration register indexes
  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  // One stored vertex
  typedef struct packed {
    logic [2:0][COORD_W-1:0] pos;
    logic [2:0][COORD_W-1:0] nrm;
    logic [1:0][COORD_W-1:0] tex;
  } vertex_t;

  // Absolute difference of two signed components below tolerance
  function automatic logic close_fn(input logic [COORD_W-1:0] a,
                                    input logic [COORD_W-1:0] b,
                                    input logic [TOL_W-1:0]   tol);
    logic [COORD_W:0] diff;
    logic [COORD_W:0] mag;
    diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
    return mag < {2'b00, tol};
  endfunction

  // Magnitude of a signed component, as unsigned
  function automatic logic [COORD_W-1:0] mag_fn(input logic [COORD_W-1:0] x);
    return x[COORD_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

/* rtl/vertex_weld_indexer.sv */
`timescale 1ns / 1ps
// Add vertex: squares on the shared multiplier, then the normal length root, the three
// component divides, a read and compare per stored vertex scanned, then ends the scan
// and commits; a zero normal skips root and divides.
// End mesh: radius root. Begin mesh and code three: result in the cycle after start.
// One request at a time, next accepted in the result cycle; done cannot be stalled.
// Reset clears counts and largest radius, sets capacity to 1024, clears tolerance; table contents stay undefined.
module vertex_weld_indexer #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [vwi_pkg::OP_W-1:0]        operation,
  input  logic signed [vwi_pkg::COORD_W-1:0] pos_x,
  input  logic signed [vwi_pkg::COORD_W-1:0] pos_y,
  input  logic signed [vwi_pkg::COORD_W-1:0] pos_z,
  input  logic signed [vwi_pkg::COORD_W-1:0] norm_x,
  input  logic signed [vwi_pkg::COORD_W-1:0] norm_y,
  input  logic signed [vwi_pkg::COORD_W-1:0] norm_z,
  input  logic signed [vwi_pkg::COORD_W-1:0] tex_u,
  input  logic signed [vwi_pkg::COORD_W-1:0] tex_v,
  output logic                            done,
  output logic [vwi_pkg::VIDX_W-1:0]      vertex_index,
  output logic                            is_new,
  output logic [vwi_pkg::STATUS_W-1:0]    status,
  output logic [vwi_pkg::CAP_W-1:0]       unique_count,
  output logic [vwi_pkg::CAP_W-1:0]       index_count,
  output logic [vwi_pkg::ROOT_W-1:0]      bounding_radius,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [vwi_pkg::TOL_W-1:0]       cfg_data
);
  import vwi_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_NORM, S_ROOTW, S_DIV, S_DIVW,
    S_RD, S_CMP, S_COMMIT, S_RAD, S_RADW
  } state_t;

  state_t             state;
  logic [OP_W-1:0]    op_q;
  vertex_t            cur;
  logic [2:0]         k;
  logic [1:0]         dk;
  logic [COORD_W-1:0] mul_a;
  logic [SQ_W-1:0]    prod;
  logic [SQ_W-1:0]    s_acc;
  logic [SQ_W-1:0]    r2_acc;
  logic [ROOT_W-1:0]  len;
  logic [CW-1:0]      i;
  logic               found;
  logic [CW-1:0]      stored;
  logic [CW-1:0]      emitted;
  logic [SQ_W-1:0]    max_r2;
  logic [CAP_W-1:0]   cap;
  logic [TOL_W-1:0]   tol;

  vertex_t            mem [TABLE_DEPTH];
  vertex_t            rd_data;
  logic [AW-1:0]      rd_addr;

  logic                  sq_start;
  logic [SQ_W-1:0]       sq_operand;
  logic                  sq_done;
  logic [ROOT_W-1:0]     sq_root;
  logic                  rad_kick;
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quo;
  logic [COORD_W-1:0]    nsel;
  logic [COORD_W-1:0]    qneg;

  logic [LW-1:0] lim;
  logic [LW-1:0] stored_ext;
  logic [LW-1:0] emitted_ext;
  logic [LW-1:0] i_ext;
  logic          full_idx;
  logic          full_vtx;
  logic          commit_new;
  logic          match;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  // The end request starts the root unit on entry to its wait state
  assign rad_kick = (state == S_RAD);

  // Shared root unit: normal length or bounding radius
  assign sq_start   = ((state == S_NORM) && (s_acc != '0)) || rad_kick;
  assign sq_operand = (op_q == OP_END) ? max_r2 : s_acc;

  vwi_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_operand),
    .done    (sq_done),
    .root    (sq_root)
  );

  // Shared divider for the three normal components
  assign div_start = (state == S_DIV);
  assign nsel      = cur.nrm[dk];

  vwi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag_fn(nsel), 16'h0000}),
    .divisor  (len),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign qneg = nsel[COORD_W-1] ? (~div_quo[COORD_W-1:0] + 1'b1) : div_quo[COORD_W-1:0];

  // Pick the component to square
  always_comb begin
    case (k)
      3'd0:    mul_a = mag_fn(cur.nrm[0]);
      3'd1:    mul_a = mag_fn(cur.nrm[1]);
      3'd2:    mul_a = mag_fn(cur.nrm[2]);
      3'd3:    mul_a = mag_fn(cur.pos[0]);
      3'd4:    mul_a = mag_fn(cur.pos[1]);
      default: mul_a = mag_fn(cur.pos[2]);
    endcase
  end

  // Compare the fetched entry against the request
  always_comb begin
    match = close_fn(rd_data.pos[0], cur.pos[0], tol) &&
            close_fn(rd_data.pos[1], cur.pos[1], tol) &&
            close_fn(rd_data.pos[2], cur.pos[2], tol) &&
            close_fn(rd_data.nrm[0], cur.nrm[0], tol) &&
            close_fn(rd_data.nrm[1], cur.nrm[1], tol) &&
            close_fn(rd_data.nrm[2], cur.nrm[2], tol) &&
            close_fn(rd_data.tex[0], cur.tex[0], tol) &&
            close_fn(rd_data.tex[1], cur.tex[1], tol);
  end

  // Capacity checks at commit
  always_comb begin
    stored_ext  = LW'(stored);
    emitted_ext = LW'(emitted);
    i_ext       = LW'(i);
    lim         = (LW'(cap) < LW'(TABLE_DEPTH)) ? LW'(cap) : LW'(TABLE_DEPTH);
    full_idx    = emitted_ext >= lim;
    full_vtx    = stored_ext >= lim;
    commit_new  = !full_idx && !found && !full_vtx;
  end

  assign rd_addr = i[AW-1:0];

  // Vertex table: one write, one registered read
  always_ff @(posedge clk) begin
    if (state == S_COMMIT && commit_new) begin
      mem[stored[AW-1:0]] <= cur;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer, counters and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      stored  <= '0;
      emitted <= '0;
      max_r2  <= '0;
      cap     <= CAP_RESET;
      tol     <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CAPACITY:  cap <= cfg_data[CAP_W-1:0];
          REG_TOLERANCE: tol <= cfg_data;
          default:       ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q       <= operation;
            cur.pos    <= {pos_z, pos_y, pos_x};
            cur.nrm    <= {norm_z, norm_y, norm_x};
            cur.tex    <= {tex_v, tex_u};
            k          <= '0;
            s_acc      <= '0;
            r2_acc     <= '0;
            found      <= 1'b0;
            i          <= '0;
            unique case (operation)
              OP_ADD: state <= S_MUL;
              OP_END: state <= S_RAD;
              OP_BEGIN: begin
                stored          <= '0;
                emitted         <= '0;
                max_r2          <= '0;
                done            <= 1'b1;
                vertex_index    <= '0;
                is_new          <= 1'b0;
                status          <= ST_OK;
                unique_count    <= '0;
                index_count     <= '0;
                bounding_radius <= '0;
              end
              default: begin
                done            <= 1'b1;
                vertex_index    <= '0;
                is_new          <= 1'b0;
                status          <= ST_OK;
                unique_count    <= stored_ext[CAP_W-1:0];
                index_count     <= emitted_ext[CAP_W-1:0];
                bounding_radius <= '0;
              end
            endcase
          end
        end
        S_MUL: begin
          prod  <= mul_a * mul_a;
          state <= S_ACC;
        end
        S_ACC: begin
          if (k < 3'd3) begin
            s_acc <= s_acc + prod;
          end else begin
            r2_acc <= r2_acc + prod;
          end
          k     <= k + 1'b1;
          state <= (k == 3'd5) ? S_NORM : S_MUL;
        end
        S_NORM: begin
          dk    <= '0;
          state <= (s_acc != '0) ? S_ROOTW : S_RD;
        end
        S_ROOTW: begin
          if (sq_done) begin
            len   <= sq_root;
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            cur.nrm[dk] <= qneg;
            dk          <= dk + 1'b1;
            state       <= (dk == 2'd2) ? S_RD : S_DIV;
          end
        end
        S_RD: begin
          state <= (i >= stored) ? S_COMMIT : S_CMP;
        end
        S_CMP: begin
          if (match) begin
            found <= 1'b1;
            state <= S_COMMIT;
          end else begin
            i     <= i + 1'b1;
            state <= S_RD;
          end
        end
        S_COMMIT: begin
          done            <= 1'b1;
          bounding_radius <= '0;
          vertex_index    <= '0;
          is_new          <= 1'b0;
          status          <= ST_OK;
          unique_count    <= stored_ext[CAP_W-1:0];
          index_count     <= emitted_ext[CAP_W-1:0];
          if (full_idx) begin
            status <= ST_IDX_FULL;
          end else if (found) begin
            vertex_index <= i_ext[VIDX_W-1:0];
            emitted      <= emitted + 1'b1;
            index_count  <= CAP_W'(emitted_ext + 1'b1);
          end else if (full_vtx) begin
            status <= ST_VTX_FULL;
          end else begin
            vertex_index <= stored_ext[VIDX_W-1:0];
            is_new       <= 1'b1;
            stored       <= stored + 1'b1;
            emitted      <= emitted + 1'b1;
            unique_count <= CAP_W'(stored_ext + 1'b1);
            index_count  <= CAP_W'(emitted_ext + 1'b1);
            if (r2_acc > max_r2) begin
              max_r2 <= r2_acc;
            end
          end
          state <= S_IDLE;
        end
        S_RAD: state <= S_RADW;
        S_RADW: begin
          if (sq_done) begin
            done            <= 1'b1;
            vertex_index    <= '0;
            is_new          <= 1'b0;
            status          <= ST_OK;
            unique_count    <= stored_ext[CAP_W-1:0];
            index_count     <= emitted_ext[CAP_W-1:0];
            bounding_radius <= sq_root;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Results come out only once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Every accepted request either runs or answers at once
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request vanished");

  // Each stored vertex was emitted at least once
  a_counts: assert property (@(posedge clk) disable iff (rst) stored <= emitted)
    else $error("unique count above index count");

  // A newly stored vertex is never flagged
  a_new_ok: assert property (@(posedge clk) disable iff (rst)
    (done && is_new) |-> (status == ST_OK))
    else $error("new vertex with error status");

endmodule

/* rtl/vwi_isqrt.sv */
`timescale 1ns / 1ps
module vwi_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [vwi_pkg::SQ_W-1:0]  operand,
  output logic                      done,
  output logic [vwi_pkg::ROOT_W-1:0] root
);
  import vwi_pkg::*;

  logic            run;
  logic [SQ_W-1:0] v;
  logic [SQ_W-1:0] r;
  logic [SQ_W-1:0] bitm;
  logic [SQ_W:0]   trial;
  logic            ge;

  // Trial subtract of one result bit
  always_comb begin
    trial = {1'b0, r} + {1'b0, bitm};
    ge    = {1'b0, v} >= trial;
  end

  // Resolve one root bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= operand;
        r    <= '0;
        bitm <= {2'b01, {(SQ_W-2){1'b0}}};
        run  <= 1'b1;
      end else if (run) begin
        if (ge) begin
          v <= v - trial[SQ_W-1:0];
          r <= (r >> 1) + bitm;
        end else begin
          r <= r >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = r[ROOT_W-1:0];

endmodule

/* rtl/vwi_div.sv */
`timescale 1ns / 1ps
module vwi_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vwi_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [vwi_pkg::ROOT_W-1:0]     divisor,
  output logic                          done,
  output logic [vwi_pkg::DIVIDEND_W-1:0] quotient
);
  import vwi_pkg::*;

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [ROOT_W-1:0]    rem;
  logic [ROOT_W-1:0]    dsr;
  logic [ROOT_W:0]      trial;
  logic [ROOT_W:0]      diff;
  logic                 ge;

  // Shift in one dividend bit and try the subtract
  always_comb begin
    trial = {rem, quotient[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dsr};
    ge    = trial >= {1'b0, dsr};
  end

  // Restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
        cnt      <= DIV_CNT_W'(DIVIDEND_W - 1);
        run      <= 1'b1;
      end else if (run) begin
        rem      <= ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
  import vwi_pkg::*;

  typedef struct {
    logic [VIDX_W-1:0]   vidx;
    logic                fresh;
    logic [STATUS_W-1:0] st;
    logic [CAP_W-1:0]    uniq;
    logic [CAP_W-1:0]    idx;
    logic [ROOT_W-1:0]   radius;
  } weld_result_t;

  localparam int DEPTH = 1024;

  // Welding predictor with its own mesh tables and the queue of pending results
  class weld_scoreboard;
    logic signed [COORD_W-1:0] pos_tab [DEPTH][3];
    logic signed [COORD_W-1:0] nrm_tab [DEPTH][3];
    logic signed [COORD_W-1:0] tex_tab [DEPTH][2];
    int unsigned       stored;
    int unsigned       emitted;
    logic [63:0]       max_r2 = '0;
    int unsigned       cap_limit = 1024;
    logic [TOL_W-1:0]  tolerance = '0;
    weld_result_t      pending[$];
    bit                failed;

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] magn(logic signed [COORD_W-1:0] x);
      longint sx;
      sx = x;
      return sx < 0 ? -sx : sx;
    endfunction

    function bit near(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d < longint'({1'b0, tolerance});
    endfunction

    function void set_reg(logic which, logic [TOL_W-1:0] data);
      if (which == REG_CAPACITY) cap_limit = data[CAP_W-1:0];
      else tolerance = data;
    endfunction

    // Predict the result of one accepted request
    function void note_request(logic [OP_W-1:0] op, vertex_t v);
      weld_result_t e;
      logic signed [COORD_W-1:0] p[3], n[3], t[2];
      logic [63:0] s, len, q, r2;
      int unsigned lim, i;
      bit hit;
      e = '{default: '0};
      if (op == OP_BEGIN) begin
        stored = 0;
        emitted = 0;
        max_r2 = 0;
      end else if (op == OP_END) begin
        e.radius = ROOT_W'(root64(max_r2));
      end else if (op == OP_ADD) begin
        s = 0;
        for (int k = 0; k < 3; k++) begin
          p[k] = v.pos[k];
          n[k] = v.nrm[k];
          s += magn(n[k]) * magn(n[k]);
        end
        t[0] = v.tex[0];
        t[1] = v.tex[1];
        // scale the normal to unit length, zero stays zero
        if (s != 0) begin
          len = root64(s);
          for (int k = 0; k < 3; k++) begin
            q = (magn(n[k]) << 16) / len;
            n[k] = n[k] < 0 ? -q[31:0] : q[31:0];
          end
        end
        lim = cap_limit < DEPTH ? cap_limit : DEPTH;
        hit = 0;
        for (i = 0; i < stored; i++) begin
          if (near(pos_tab[i][0], p[0]) && near(pos_tab[i][1], p[1]) &&
              near(pos_tab[i][2], p[2]) && near(nrm_tab[i][0], n[0]) &&
              near(nrm_tab[i][1], n[1]) && near(nrm_tab[i][2], n[2]) &&
              near(tex_tab[i][0], t[0]) && near(tex_tab[i][1], t[1])) begin
            hit = 1;
            break;
          end
        end
        if (emitted >= lim) begin
          e.st = ST_IDX_FULL;
        end else if (hit) begin
          e.vidx = VIDX_W'(i);
          emitted++;
        end else if (stored >= lim) begin
          e.st = ST_VTX_FULL;
        end else begin
          i = stored;
          for (int k = 0; k < 3; k++) begin
            pos_tab[i][k] = p[k];
            nrm_tab[i][k] = n[k];
          end
          tex_tab[i][0] = t[0];
          tex_tab[i][1] = t[1];
          r2 = magn(p[0]) * magn(p[0]) + magn(p[1]) * magn(p[1]) +
               magn(p[2]) * magn(p[2]);
          if (r2 > max_r2) max_r2 = r2;
          e.vidx = VIDX_W'(i);
          e.fresh = 1;
          stored++;
          emitted++;
        end
      end
      e.uniq = CAP_W'(stored);
      e.idx = CAP_W'(emitted);
      pending.push_back(e);
    endfunction

    function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
        failed = 1;
      end
    endfunction

    function void check_result(weld_result_t a);
      weld_result_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result, vertex_index %0h", $time, a.vidx);
        failed = 1;
        return;
      end
      e = pending.pop_front();
      field("vertex_index", e.vidx, a.vidx);
      field("is_new", e.fresh, a.fresh);
      field("status", e.st, a.st);
      field("unique_count", e.uniq, a.uniq);
      field("index_count", e.idx, a.idx);
      field("bounding_radius", e.radius, a.radius);
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, busy, done;
  logic [OP_W-1:0] operation = OP_ADD;
  logic signed [COORD_W-1:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic signed [COORD_W-1:0] norm_x = 0, norm_y = 0, norm_z = 0, tex_u = 0, tex_v = 0;
  logic [VIDX_W-1:0] vertex_index;
  logic is_new;
  logic [STATUS_W-1:0] status;
  logic [CAP_W-1:0] unique_count, index_count;
  logic [ROOT_W-1:0] bounding_radius;
  logic cfg_valid = 0, cfg_ready, cfg_index = 0;
  logic [TOL_W-1:0] cfg_data = 0;

  weld_scoreboard sb = new();
  int sent;
  bit calm;

  vertex_weld_indexer dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Check every strobed result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result('{vertex_index, is_new, status, unique_count, index_count,
                        bounding_radius});
  end

  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (calm || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3: return $urandom_range(0, 8) - 4;
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function vertex_t pick_vertex();
    vertex_t v;
    for (int k = 0; k < 3; k++) begin
      v.pos[k] = pick_coord();
      v.nrm[k] = $urandom_range(0, 9) == 0 ? 0 : pick_coord();
    end
    v.tex[0] = pick_coord();
    v.tex[1] = pick_coord();
    return v;
  endfunction

  // Drive one request; start stays high until the next call decides
  task send(logic [OP_W-1:0] op, vertex_t v);
    int g;
    g = pick_gap();
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
    operation <= op;
    {pos_x, pos_y, pos_z} <= {v.pos[0], v.pos[1], v.pos[2]};
    {norm_x, norm_y, norm_z} <= {v.nrm[0], v.nrm[1], v.nrm[2]};
    {tex_u, tex_v} <= {v.tex[0], v.tex[1]};
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_request(op, v);
    sent++;
  endtask

  task drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
  endtask

  // Write one register while the block is idle
  task write_reg(logic which, logic [TOL_W-1:0] data);
    drain();
    cfg_index <= which;
    cfg_data <= data;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(which, data);
  endtask

  // Begin, a run of adds with many repeats and some random requests mixed in, then end
  task run_mesh(int n_adds);
    vertex_t pool[$];
    vertex_t v;
    send(OP_BEGIN, pick_vertex());
    for (int j = 0; j < n_adds; j++) begin
      if ($urandom_range(0, 9) == 0) send(OP_W'($urandom_range(0, 3)), pick_vertex());
      if (pool.size() != 0 && $urandom_range(0, 9) < 4) begin
        v = pool[$urandom_range(0, pool.size() - 1)];
        if ($urandom_range(0, 1)) v.pos[$urandom_range(0, 2)] += $urandom_range(0, 6) - 3;
        if ($urandom_range(0, 3) == 0) v.tex[$urandom_range(0, 1)] += $urandom_range(0, 2) - 1;
      end else begin
        v = pick_vertex();
      end
      pool.push_back(v);
      send(OP_ADD, v);
    end
    send(OP_END, pick_vertex());
  endtask

  initial begin
    vertex_t a, b;
    repeat (5) @(posedge clk);
    rst <= 0;
    calm = 1;

    // Directed: extremes, zero normal, unused code, zero tolerance
    a.pos = {3{32'h8000_0000}};
    a.nrm = {3{32'h8000_0000}};
    a.tex = {2{32'h8000_0000}};
    b.pos = {3{32'h7FFF_FFFF}};
    b.nrm = {3{32'h7FFF_FFFF}};
    b.tex = {2{32'h7FFF_FFFF}};
    send(OP_ADD, a);
    send(OP_ADD, b);
    send(OP_ADD, a);
    b.nrm = '0;
    send(OP_ADD, b);
    send(2'd3, b);
    send(OP_END, a);
    send(OP_BEGIN, a);
    send(OP_END, a);

    // Directed: widest tolerance, capacity one, then index list full
    write_reg(REG_TOLERANCE, 31'h7FFF_FFFF);
    write_reg(REG_CAPACITY, 1);
    send(OP_ADD, a);
    send(OP_ADD, a);
    send(OP_ADD, b);
    send(OP_END, a);
    write_reg(REG_CAPACITY, 2);
    send(OP_BEGIN, a);
    send(OP_ADD, a);
    send(OP_ADD, b);
    send(OP_ADD, a);
    send(OP_END, b);
    write_reg(REG_CAPACITY, 0);
    send(OP_BEGIN, a);
    send(OP_ADD, b);

    // Random phases of register settings and meshes
    while (sent < 750) begin
      calm = $urandom_range(0, 4) == 0;
      case ($urandom_range(0, 5))
        0: write_reg(REG_CAPACITY, 1024);
        1: write_reg(REG_CAPACITY, 2047);
        2: write_reg(REG_CAPACITY, $urandom_range(0, 4));
        default: write_reg(REG_CAPACITY, $urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_TOLERANCE, 0);
        1: write_reg(REG_TOLERANCE, 31'h7FFF_FFFF);
        2: write_reg(REG_TOLERANCE, $urandom);
        default: write_reg(REG_TOLERANCE, $urandom_range(1, 8));
      endcase
      repeat ($urandom_range(1, 4))
        run_mesh($urandom_range(0, 9) == 0 ? $urandom_range(60, 150) : $urandom_range(1, 25));
    end

    drain();
    repeat (50) @(posedge clk);
    if (!sb.failed && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
